@@ sv/llm_pkg.sv @@
// shared types and constants for the lucas-lehmer test unit
`default_nettype none
package llm_pkg;
    localparam int W = 127;
    localparam int PW = 7;

    typedef logic [W-1:0] word_t;
    typedef logic [PW-1:0] expo_t;

    // control handed from the sequencer to the cell row
    typedef struct packed {
        word_t mask;
        expo_t top;
        logic  add_bit;
    } row_ctl_t;
endpackage
`default_nettype wire

@@ sv/llm_cell.sv @@
// one bit cell of the carry-save modular accumulator
`default_nettype none
module llm_cell (
    input  wire logic s_in,
    input  wire logic c_in,
    input  wire logic a_in,
    input  wire logic en,
    output logic      s_out,
    output logic      c_out
);
    assign s_out = en & (s_in ^ c_in ^ a_in);
    assign c_out = en & ((s_in & c_in) | (s_in & a_in) | (c_in & a_in));
endmodule
`default_nettype wire

@@ sv/llm_row.sv @@
// row of bit cells: acc = 2*acc + addend mod 2^p-1, kept in carry-save form
`default_nettype none
module llm_row (
    input  wire llm_pkg::word_t    sum_q,
    input  wire llm_pkg::word_t    car_q,
    input  wire llm_pkg::word_t    addend,
    input  wire llm_pkg::row_ctl_t ctl,
    output llm_pkg::word_t         sum_d,
    output llm_pkg::word_t         car_d
);
    import llm_pkg::*;

    word_t s_rot;
    word_t c_rot;
    word_t cout;

    // doubling mod 2^p-1 is a rotation within the low p bits
    assign s_rot = {sum_q[W-2:0], sum_q[ctl.top]};
    assign c_rot = {car_q[W-2:0], car_q[ctl.top]};

    for (genvar i = 0; i < W; i++) begin : g_cell
        llm_cell u_cell (
            .s_in  (s_rot[i]),
            .c_in  (c_rot[i]),
            .a_in  (addend[i] & ctl.add_bit),
            .en    (ctl.mask[i]),
            .s_out (sum_d[i]),
            .c_out (cout[i])
        );
    end

    // carry out of the top live cell wraps to bit zero
    assign car_d = {cout[W-2:0] & ctl.mask[W-1:1], cout[ctl.top]};
endmodule
`default_nettype wire

@@ sv/lucas_lehmer_mersenne_test_unit.sv @@
// top level of the lucas-lehmer mersenne test unit
// for 3 <= p <= bound, out_valid rises once p-2 iterations are done
// each iteration scans p residue bits through the carry-save cell row, then one fold, one minus two
// out-of-range exponents and p = 2 skip the iterations and go straight to the output state
// one item at a time, in_ready returns as the result enters the output register
// reset: rst_n asynchronous active low, clears state, residue, mask and output beat
`default_nettype none
module lucas_lehmer_mersenne_test_unit #(
    parameter int MAX_EXPONENT = 127
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire llm_pkg::expo_t    exponent,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output llm_pkg::expo_t         exponent_echo,
    output logic                   is_mersenne_prime,
    output logic                   out_of_range
);
    import llm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_RES  = 3'd2;
    localparam logic [2:0] ST_SUB  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg, state_next;
    expo_t      p_reg, p_next;
    expo_t      bit_reg, bit_next;       // residue bit being scanned, msb first
    expo_t      iter_reg, iter_next;     // iterations done
    word_t      residue_reg, residue_next;
    word_t      mask_reg, mask_next;
    word_t      sum_reg, sum_next;
    word_t      car_reg, car_next;
    logic       prime_reg, prime_next;
    logic       oor_reg, oor_next;
    logic       ovalid_reg, ovalid_next;
    expo_t      oexp_reg, oexp_next;
    logic       oprime_reg, oprime_next;
    logic       ooor_reg, ooor_next;

    row_ctl_t   ctl;
    word_t      row_sum, row_car;
    word_t      in_mask;
    logic [W:0] cs_total;
    word_t      folded;
    expo_t      p_less_one;
    logic       in_oor;

    assign in_ready = (state_reg == ST_IDLE);
    assign p_less_one = p_reg - expo_t'(1);
    assign in_oor = (exponent < expo_t'(2)) || (int'(exponent) > MAX_EXPONENT);

    // mask of the live bits for an incoming exponent
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            in_mask[i] = (PW'(i) < exponent);
        end
    end

    assign ctl = '{mask: mask_reg, top: p_less_one, add_bit: residue_reg[bit_reg]};

    // squaring by horner scan: acc = 2*acc + bit*s, one residue bit per cycle
    llm_row u_row (
        .sum_q  (sum_reg),
        .car_q  (car_reg),
        .addend (residue_reg),
        .ctl    (ctl),
        .sum_d  (row_sum),
        .car_d  (row_car)
    );

    // collapse carry-save pair, end-around carry of 2^p
    assign cs_total = {1'b0, sum_reg} + {1'b0, car_reg};
    assign folded   = (cs_total[W-1:0] & mask_reg) + word_t'(cs_total[p_reg]);

    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        bit_next     = bit_reg;
        iter_next    = iter_reg;
        residue_next = residue_reg;
        mask_next    = mask_reg;
        sum_next     = sum_reg;
        car_next     = car_reg;
        prime_next   = prime_reg;
        oor_next     = oor_reg;
        ovalid_next  = ovalid_reg;
        oexp_next    = oexp_reg;
        oprime_next  = oprime_reg;
        ooor_next    = ooor_reg;

        if (out_ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p_next   = exponent;
                    oor_next = in_oor;
                    if (in_oor || exponent == expo_t'(2))
                    begin
                        prime_next = !in_oor;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        mask_next    = in_mask;
                        residue_next = word_t'(4);
                        iter_next    = '0;
                        sum_next     = '0;
                        car_next     = '0;
                        bit_next     = exponent - expo_t'(1);
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                sum_next = row_sum;
                car_next = row_car;
                bit_next = bit_reg - expo_t'(1);
                if (bit_reg == '0)
                begin
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                residue_next = (folded == mask_reg) ? '0 : folded;
                state_next   = ST_SUB;
            end
            ST_SUB:
            begin
                // minus two, wrapping modulo M for residues below two
                if (residue_reg < word_t'(2))
                begin
                    residue_next = mask_reg - (word_t'(2) - residue_reg);
                end
                else
                begin
                    residue_next = residue_reg - word_t'(2);
                end
                iter_next = iter_reg + expo_t'(1);
                sum_next  = '0;
                car_next  = '0;
                bit_next  = p_less_one;
                if (iter_reg + expo_t'(1) == p_reg - expo_t'(2))
                begin
                    prime_next = (residue_next == '0);
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    oexp_next   = p_reg;
                    oprime_next = prime_reg;
                    ooor_next   = oor_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            p_reg       <= '0;
            bit_reg     <= '0;
            iter_reg    <= '0;
            residue_reg <= '0;
            mask_reg    <= '0;
            sum_reg     <= '0;
            car_reg     <= '0;
            prime_reg   <= 1'b0;
            oor_reg     <= 1'b0;
            ovalid_reg  <= 1'b0;
            oexp_reg    <= '0;
            oprime_reg  <= 1'b0;
            ooor_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            bit_reg     <= bit_next;
            iter_reg    <= iter_next;
            residue_reg <= residue_next;
            mask_reg    <= mask_next;
            sum_reg     <= sum_next;
            car_reg     <= car_next;
            prime_reg   <= prime_next;
            oor_reg     <= oor_next;
            ovalid_reg  <= ovalid_next;
            oexp_reg    <= oexp_next;
            oprime_reg  <= oprime_next;
            ooor_reg    <= ooor_next;
        end
    end

    // output beat register
    assign out_valid         = ovalid_reg;
    assign exponent_echo     = oexp_reg;
    assign is_mersenne_prime = oprime_reg;
    assign out_of_range      = ooor_reg;

    // residue never holds bits above the live width while squaring
    a_residue_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> ((residue_reg & ~mask_reg) == '0))
        else $error("residue outside modulus width");

    // carry-save pair stays within the live width
    a_cs_masked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (((sum_reg | car_reg) & ~mask_reg) == '0))
        else $error("carry-save pair outside modulus width");

    // iteration count stays below p-2 while working
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (iter_reg < p_reg - expo_t'(2)))
        else $error("iteration count past its bound");

    // a flagged exponent is never reported prime
    a_oor_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_of_range && is_mersenne_prime))
        else $error("out-of-range beat marked prime");
endmodule
`default_nettype wire
